// File: hw/rtl/assert_macros.svh
// Assertion macros for the accumulator core.
// CLLA_ASSERT expects clk and rst_n in scope; CLLA_ASSERT_ALWAYS expects clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property while out of reset.
`define CLLA_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define CLLA_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/clla_pkg.sv
// ----------------------------------------------------------------------------
// clla_pkg
// Types and constants for the tree lookup-table likelihood accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package clla_pkg;

    localparam int NUM_WORDS      = 4096;
    localparam int SLOTS_PER_WORD = 8;
    localparam int ADDR_BITS      = $clog2(NUM_WORDS);
    localparam int SLOT_BITS      = $clog2(SLOTS_PER_WORD);
    localparam int TBL_ADDR_BITS  = ADDR_BITS + SLOT_BITS;
    localparam int TBL_DEPTH      = NUM_WORDS * SLOTS_PER_WORD;

    localparam int OP_BITS    = 2;
    localparam int WORD_BITS  = 12;
    localparam int VALUE_BITS = 31;
    localparam int SUM_BITS   = 47;

    // Wide enough to compare a word field against NUM_WORDS at any legal value
    localparam int CMP_BITS = 18;

    localparam logic [OP_BITS-1:0] OP_LOAD_TABLE  = 2'd0;
    localparam logic [OP_BITS-1:0] OP_LOAD_PARENT = 2'd1;
    localparam logic [OP_BITS-1:0] OP_LOAD_QUERY  = 2'd2;
    localparam logic [OP_BITS-1:0] OP_SCORE       = 2'd3;

    localparam logic [CMP_BITS-1:0] NUM_WORDS_CMP = CMP_BITS'(NUM_WORDS);

    typedef struct packed {
        logic [OP_BITS-1:0]    op;
        logic [WORD_BITS-1:0]  word_index;
        logic [SLOT_BITS-1:0]  entry_select;
        logic [VALUE_BITS-1:0] table_value;
        logic [WORD_BITS-1:0]  parent_word;
        logic                  bit_value;
        logic                  last;
    } clla_in_t;

    typedef struct packed {
        logic [SUM_BITS-1:0] score_sum;
    } clla_out_t;

    function automatic logic word_in_range(input logic [WORD_BITS-1:0] w);
        return {{(CMP_BITS-WORD_BITS){1'b0}}, w} < NUM_WORDS_CMP;
    endfunction

endpackage

// File: hw/rtl/clla_in_if.sv
// ----------------------------------------------------------------------------
// clla_in_if
// Valid/ready channel carrying load and score items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface clla_in_if import clla_pkg::*; ();
    logic     valid;
    logic     ready;
    clla_in_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/clla_out_if.sv
// ----------------------------------------------------------------------------
// clla_out_if
// Valid/ready channel carrying score results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface clla_out_if import clla_pkg::*; ();
    logic      valid;
    logic      ready;
    clla_out_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/chow_liu_lut_likelihood_accumulator_core.sv
// ----------------------------------------------------------------------------
// chow_liu_lut_likelihood_accumulator_core
// Scores test words against a stored query through a per-word table of
// eight costs selected by test, query and parent-query presence bits.
//
//   Channel  Dir  Carries
//   cmd      in   load table / parent / query items and score items
//   score    out  saturated score sum, one per descriptor (last word)
//
// Load items write their memory on the accepting edge.
// Score items step through parent and query read, parent query read,
// table read and accumulate. The single read port of the query memory is
// used twice per word, and each read supplies the address of the next.
// No clearing pass after reset: the memories are undefined until loaded.
// A last word waits in the accumulate step while the result register is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module chow_liu_lut_likelihood_accumulator_core
    import clla_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    clla_in_if.sink           cmd,
    clla_out_if.source        score
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD1  = 2'd1;
    localparam logic [1:0] S_RD2  = 2'd2;
    localparam logic [1:0] S_ACC  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Memories
    logic [VALUE_BITS-1:0] prob_mem   [TBL_DEPTH];
    logic [WORD_BITS-1:0]  parent_mem [NUM_WORDS];
    logic                  query_mem  [NUM_WORDS];

    logic [VALUE_BITS-1:0] table_rdata_reg;
    logic [WORD_BITS-1:0]  parent_rdata_reg;
    logic                  query_rdata_reg;

    // Item context
    logic [ADDR_BITS-1:0] word_reg;
    logic                 word_ok_reg;
    logic                 bit_reg;
    logic                 last_reg;
    logic                 zq_reg;
    logic                 pok_reg;
    logic                 zpq_reg;

    logic [SUM_BITS-1:0] sum_reg;
    logic [SUM_BITS-1:0] out_sum_reg;
    logic                out_valid_reg;

    logic                     accept;
    logic                     in_ok;
    logic [ADDR_BITS-1:0]     in_addr;
    logic                     zpq_now;
    logic [ADDR_BITS-1:0]     query_raddr;
    logic [TBL_ADDR_BITS-1:0] tbl_raddr;
    logic [TBL_ADDR_BITS-1:0] tbl_waddr;
    logic [SUM_BITS:0]        sum_wide;
    logic [SUM_BITS-1:0]      sum_sat;
    logic                     out_free;
    logic                     acc_done;

    assign accept  = cmd.valid && cmd.ready;
    assign in_ok   = word_in_range(cmd.payload.word_index);
    assign in_addr = cmd.payload.word_index[ADDR_BITS-1:0];

    assign cmd.ready           = (state_reg == S_IDLE);
    assign score.valid         = out_valid_reg;
    assign score.payload.score_sum = out_sum_reg;

    assign zpq_now     = (state_reg == S_RD2) ? (query_rdata_reg & pok_reg) : zpq_reg;
    assign query_raddr = (state_reg == S_IDLE) ? in_addr
                                               : parent_rdata_reg[ADDR_BITS-1:0];
    assign tbl_raddr   = {word_reg, bit_reg, zq_reg, zpq_now};
    assign tbl_waddr   = {in_addr, cmd.payload.entry_select};

    // Saturating accumulate
    assign sum_wide = {1'b0, sum_reg}
                    + {{(SUM_BITS+1-VALUE_BITS){1'b0}},
                       (word_ok_reg ? table_rdata_reg : {VALUE_BITS{1'b0}})};
    assign sum_sat  = sum_wide[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_wide[SUM_BITS-1:0];

    assign out_free = !out_valid_reg || score.ready;
    assign acc_done = (state_reg == S_ACC) && (!last_reg || out_free);

    always_ff @(posedge clk)
    begin
        if (accept && cmd.payload.op == OP_LOAD_TABLE && in_ok)
        begin
            prob_mem[tbl_waddr] <= cmd.payload.table_value;
        end
        table_rdata_reg <= prob_mem[tbl_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (accept && cmd.payload.op == OP_LOAD_PARENT && in_ok)
        begin
            parent_mem[in_addr] <= cmd.payload.parent_word;
        end
        parent_rdata_reg <= parent_mem[in_addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept && cmd.payload.op == OP_LOAD_QUERY && in_ok)
        begin
            query_mem[in_addr] <= cmd.payload.bit_value;
        end
        query_rdata_reg <= query_mem[query_raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && cmd.payload.op == OP_SCORE)
                begin
                    state_next = S_RD1;
                end
            end
            S_RD1:   state_next = S_RD2;
            S_RD2:   state_next = S_ACC;
            S_ACC:
            begin
                if (acc_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Item context needs no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg    <= in_addr;
            word_ok_reg <= in_ok;
            bit_reg     <= cmd.payload.bit_value;
            last_reg    <= cmd.payload.last;
        end
        if (state_reg == S_RD1)
        begin
            zq_reg  <= query_rdata_reg;
            pok_reg <= word_in_range(parent_rdata_reg);
        end
        if (state_reg == S_RD2)
        begin
            zpq_reg <= zpq_now;
        end
        if (acc_done && last_reg)
        begin
            out_sum_reg <= sum_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (acc_done)
            begin
                // Clear on the last word, else carry the total forward
                sum_reg <= last_reg ? {SUM_BITS{1'b0}} : sum_sat;
            end
            if (acc_done && last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (score.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `CLLA_ASSERT(a_score_starts_read,
        (accept && cmd.payload.op == OP_SCORE) |=> (state_reg == S_RD1),
        "score item did not start the read sequence")
    `CLLA_ASSERT(a_result_from_acc,
        $rose(score.valid) |-> ($past(state_reg) == S_ACC && $past(last_reg)),
        "result appeared outside the accumulate step of a last word")
    `CLLA_ASSERT(a_sum_cleared,
        (acc_done && last_reg) |=> (sum_reg == '0),
        "running sum not cleared after a result")
    `CLLA_ASSERT_ALWAYS(a_no_result_in_reset,
        !rst_n |-> !score.valid,
        "result valid during reset")

endmodule
